FILE: rtl/sfph_pkg.sv
package sfph_pkg;

  // Fixed field widths
  localparam int STRIDE_W   = 16;
  localparam int WINDOW_W   = 31;
  localparam int RECIP_W    = 32;
  localparam int FRAME_W    = 32;
  localparam int AGE_W      = 16;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register values after reset
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd1;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 31'd48000;
  localparam logic [RECIP_W-1:0]  RECIP_RST  = 32'd89478;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_STRIDE   = 2'd0,
    CFG_WINDOW_FRAMES  = 2'd1,
    CFG_AGE_RECIPROCAL = 2'd2,
    CFG_MONO_MODE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE_WRITE,
    ST_SAMPLE_FETCH,
    ST_SAMPLE_EXPIRE,
    ST_POINT_FETCH,
    ST_AGE_MUL,
    ST_RESULT,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic accept;
    logic sample_write;
    logic sample_fetch;
    logic sample_expire;
    logic point_fetch;
    logic age_mul;
    logic out_load;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

FILE: rtl/sfph_if.sv
interface sfph_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int POINT_SLOTS = 512
) ();
  localparam int IdxW = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;

  logic                          valid;
  logic                          ready;
  logic [sfph_pkg::REQ_W-1:0]    req_type;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic [IdxW-1:0]               read_index;

  modport source (output valid, req_type, left_sample, right_sample, read_index, input ready);
  modport sink   (input valid, req_type, left_sample, right_sample, read_index, output ready);
endinterface

interface sfph_out_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int POINT_SLOTS = 512
) ();
  localparam int CntW = $clog2(POINT_SLOTS + 1);

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] side_value;
  logic signed [SAMPLE_BITS-1:0] mid_value;
  logic [sfph_pkg::AGE_W-1:0]    normalized_age;
  logic                          point_valid;
  logic [CntW-1:0]               points_held;

  modport source (output valid, side_value, mid_value, normalized_age, point_valid, points_held,
                  input ready);
  modport sink   (input valid, side_value, mid_value, normalized_age, point_valid, points_held,
                  output ready);
endinterface

FILE: rtl/stereo_field_point_history.sv
// Stereo field point history. Takes one request per input transfer: a stereo
// sample frame (kept every point_stride frames as side (R-L)/2 and mid (L+R)/2,
// or 0 and left in mono mode, with a 32-bit frame stamp), a point read (one
// result transfer with the point counted from the oldest, its age scaled to
// unsigned Q0.16 and the point count), or a clear. Sample frames and clears
// give no result. Points live in a single-port-read ring RAM of POINT_SLOTS
// entries; when full the oldest point is overwritten, and after each frame at
// most one point whose age has reached window_frames is dropped. The block
// takes one request at a time: a sample frame steps through accept, ring
// write, oldest-stamp fetch and expiry check, a clear through accept and
// clear, a read through accept, ring fetch, age multiply and result load,
// waiting there while the result register stays full. The steps follow from
// the ring RAM's one read port with registered read data and the registered
// 32 x 32 age multiplier. Ring contents are not cleared at reset and need no
// clearing pass: unwritten data is never used. The user must write the
// configuration via cfg_we_i/cfg_idx_i/cfg_data_i only while idle (unenforced).
module stereo_field_point_history #(
  parameter int POINT_SLOTS = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfph_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfph_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfph_in_if.sink                         in_ch,
  sfph_out_if.source                      out_ch
);

  sfph_pkg::dp_cmd_t cmd;
  sfph_pkg::dp_sts_t sts;

  // Sequencer: decodes the request and steps the datapath through it
  sfph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_req_i   (in_ch.req_type),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: registers, ring RAM, age multiplier and result register
  sfph_dp #(
    .POINT_SLOTS (POINT_SLOTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_left_i   (in_ch.left_sample),
    .in_right_i  (in_ch.right_sample),
    .in_index_i  (in_ch.read_index),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_side_o  (out_ch.side_value),
    .out_mid_o   (out_ch.mid_value),
    .out_age_o   (out_ch.normalized_age),
    .out_hit_o   (out_ch.point_valid),
    .out_held_o  (out_ch.points_held)
  );

endmodule

FILE: rtl/sfph_ram.sv
module sfph_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sfph_ctrl.sv
module sfph_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [sfph_pkg::REQ_W-1:0] in_req_i,
  output logic                       in_ready_o,
  input  sfph_pkg::dp_sts_t          sts_i,
  output sfph_pkg::dp_cmd_t          cmd_o
);

  sfph_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfph_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfph_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_req_i)
            sfph_pkg::REQ_SAMPLE: state_d = sfph_pkg::ST_SAMPLE_WRITE;
            sfph_pkg::REQ_READ:   state_d = sfph_pkg::ST_POINT_FETCH;
            sfph_pkg::REQ_CLEAR:  state_d = sfph_pkg::ST_CLEAR;
            default:              state_d = sfph_pkg::ST_IDLE;
          endcase
        end
      end
      sfph_pkg::ST_SAMPLE_WRITE:  state_d = sfph_pkg::ST_SAMPLE_FETCH;
      sfph_pkg::ST_SAMPLE_FETCH:  state_d = sfph_pkg::ST_SAMPLE_EXPIRE;
      sfph_pkg::ST_SAMPLE_EXPIRE: state_d = sfph_pkg::ST_IDLE;
      sfph_pkg::ST_POINT_FETCH:   state_d = sfph_pkg::ST_AGE_MUL;
      sfph_pkg::ST_AGE_MUL:       state_d = sfph_pkg::ST_RESULT;
      sfph_pkg::ST_RESULT: begin
        if (!sts_i.out_busy) begin
          state_d = sfph_pkg::ST_IDLE;
        end
      end
      sfph_pkg::ST_CLEAR:         state_d = sfph_pkg::ST_IDLE;
      default:                    state_d = sfph_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sfph_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      sfph_pkg::ST_SAMPLE_WRITE:  cmd_o.sample_write  = 1'b1;
      sfph_pkg::ST_SAMPLE_FETCH:  cmd_o.sample_fetch  = 1'b1;
      sfph_pkg::ST_SAMPLE_EXPIRE: cmd_o.sample_expire = 1'b1;
      sfph_pkg::ST_POINT_FETCH:   cmd_o.point_fetch   = 1'b1;
      sfph_pkg::ST_AGE_MUL:       cmd_o.age_mul       = 1'b1;
      sfph_pkg::ST_RESULT:        cmd_o.out_load      = !sts_i.out_busy;
      sfph_pkg::ST_CLEAR:         cmd_o.clear         = 1'b1;
      default:                    cmd_o               = '0;
    endcase
  end

endmodule

FILE: rtl/sfph_dp.sv
module sfph_dp #(
  parameter int POINT_SLOTS = 512,
  parameter int SAMPLE_BITS = 16,
  localparam int IdxW = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1,
  localparam int CntW = $clog2(POINT_SLOTS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfph_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfph_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_left_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_right_i,
  input  logic [IdxW-1:0]                 in_index_i,
  input  sfph_pkg::dp_cmd_t               cmd_i,
  output sfph_pkg::dp_sts_t               sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]   out_side_o,
  output logic signed [SAMPLE_BITS-1:0]   out_mid_o,
  output logic [sfph_pkg::AGE_W-1:0]      out_age_o,
  output logic                            out_hit_o,
  output logic [CntW-1:0]                 out_held_o
);

  localparam int SumW   = IdxW + 1;
  localparam int EntryW = 2 * SAMPLE_BITS + sfph_pkg::FRAME_W;
  localparam int ProdW  = sfph_pkg::FRAME_W + sfph_pkg::RECIP_W;

  // Configuration registers
  logic [sfph_pkg::STRIDE_W-1:0] stride_q;
  logic [sfph_pkg::WINDOW_W-1:0] window_q;
  logic [sfph_pkg::RECIP_W-1:0]  recip_q;
  logic                          mono_q;

  // Ring state
  logic [IdxW-1:0]               oldest_q, oldest_d;
  logic [CntW-1:0]               held_q, held_d;
  logic [sfph_pkg::FRAME_W-1:0]  frame_q, frame_d;
  logic [sfph_pkg::STRIDE_W-1:0] countdown_q, countdown_d;

  // Item payload and working registers
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic [IdxW-1:0]               index_q;
  logic [ProdW-1:0]              prod_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_side_q, out_mid_q;
  logic [sfph_pkg::AGE_W-1:0]    out_age_q;
  logic                          out_hit_q;
  logic [CntW-1:0]               out_held_q;

  logic [sfph_pkg::STRIDE_W-1:0] stride_eff;
  logic [sfph_pkg::FRAME_W-1:0]  window_eff;
  logic [SumW-1:0]               append_sum, point_sum;
  logic [IdxW-1:0]               append_slot, point_slot, oldest_inc;
  logic                          ring_full, keep, expired, hit;
  logic signed [SAMPLE_BITS:0]   diff_wide, sum_wide;
  logic signed [SAMPLE_BITS-1:0] new_side, new_mid;
  logic [sfph_pkg::FRAME_W-1:0]  rd_stamp, age;
  logic signed [SAMPLE_BITS-1:0] rd_side, rd_mid;
  logic [sfph_pkg::AGE_W-1:0]    age_sat;

  logic                          ram_we, ram_re;
  logic [IdxW-1:0]               ram_waddr, ram_raddr;
  logic [EntryW-1:0]             ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= sfph_pkg::STRIDE_RST;
      window_q <= sfph_pkg::WINDOW_RST;
      recip_q  <= sfph_pkg::RECIP_RST;
      mono_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfph_pkg::CFG_POINT_STRIDE:   stride_q <= cfg_data_i[sfph_pkg::STRIDE_W-1:0];
        sfph_pkg::CFG_WINDOW_FRAMES:  window_q <= cfg_data_i[sfph_pkg::WINDOW_W-1:0];
        sfph_pkg::CFG_AGE_RECIPROCAL: recip_q  <= cfg_data_i[sfph_pkg::RECIP_W-1:0];
        sfph_pkg::CFG_MONO_MODE:      mono_q   <= cfg_data_i[0];
        default:                      mono_q   <= mono_q;
      endcase
    end
  end

  always_comb begin
    stride_eff  = (stride_q == '0) ? sfph_pkg::STRIDE_W'(1) : stride_q;
    window_eff  = {1'b0, (window_q == '0) ? sfph_pkg::WINDOW_W'(1) : window_q};

    append_sum  = SumW'(oldest_q) + SumW'(held_q);
    append_slot = (append_sum >= SumW'(POINT_SLOTS)) ?
                  IdxW'(append_sum - SumW'(POINT_SLOTS)) : IdxW'(append_sum);
    point_sum   = SumW'(oldest_q) + SumW'(index_q);
    point_slot  = (point_sum >= SumW'(POINT_SLOTS)) ?
                  IdxW'(point_sum - SumW'(POINT_SLOTS)) : IdxW'(point_sum);
    oldest_inc  = (oldest_q == IdxW'(POINT_SLOTS - 1)) ? '0 : oldest_q + 1'b1;
    ring_full   = (held_q == CntW'(POINT_SLOTS));
    keep        = (countdown_q == '0);

    // Halve with floor: arithmetic shift of the widened sum and difference
    diff_wide   = $signed({right_q[SAMPLE_BITS-1], right_q}) -
                  $signed({left_q[SAMPLE_BITS-1], left_q});
    sum_wide    = $signed({left_q[SAMPLE_BITS-1], left_q}) +
                  $signed({right_q[SAMPLE_BITS-1], right_q});
    new_side    = mono_q ? '0 : diff_wide[SAMPLE_BITS:1];
    new_mid     = mono_q ? left_q : sum_wide[SAMPLE_BITS:1];

    rd_stamp    = ram_rdata[EntryW-1 -: sfph_pkg::FRAME_W];
    rd_side     = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    rd_mid      = ram_rdata[SAMPLE_BITS-1:0];
    age         = frame_q - sfph_pkg::FRAME_W'(1) - rd_stamp;
    expired     = (held_q != '0) && (age >= window_eff);
    hit         = (CntW'(index_q) < held_q);
    age_sat     = (prod_q[ProdW-1:sfph_pkg::FRAME_W] != '0) ? '1 :
                  prod_q[sfph_pkg::FRAME_W-1:sfph_pkg::AGE_W];
  end

  // Ring pointer and counters
  always_comb begin
    oldest_d    = oldest_q;
    held_d      = held_q;
    frame_d     = frame_q;
    countdown_d = countdown_q;
    if (cmd_i.clear) begin
      oldest_d    = '0;
      held_d      = '0;
      frame_d     = '0;
      countdown_d = '0;
    end else if (cmd_i.sample_write) begin
      frame_d = frame_q + 1'b1;
      if (keep) begin
        countdown_d = stride_eff - 1'b1;
        if (ring_full) begin
          oldest_d = oldest_inc;
        end else begin
          held_d = held_q + 1'b1;
        end
      end else begin
        countdown_d = countdown_q - 1'b1;
      end
    end else if (cmd_i.sample_expire && expired) begin
      oldest_d = oldest_inc;
      held_d   = held_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      held_q      <= '0;
      frame_q     <= '0;
      countdown_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      oldest_q    <= oldest_d;
      held_q      <= held_d;
      frame_q     <= frame_d;
      countdown_q <= countdown_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      left_q  <= in_left_i;
      right_q <= in_right_i;
      index_q <= in_index_i;
    end
    if (cmd_i.age_mul) begin
      prod_q <= age * recip_q;
    end
    if (cmd_i.out_load) begin
      out_hit_q  <= hit;
      out_held_q <= held_q;
      out_side_q <= hit ? rd_side : '0;
      out_mid_q  <= hit ? rd_mid : '0;
      out_age_q  <= hit ? age_sat : '0;
    end
  end

  assign ram_we    = cmd_i.sample_write && keep;
  assign ram_waddr = ring_full ? oldest_q : append_slot;
  assign ram_wdata = {frame_q, new_side, new_mid};
  assign ram_re    = cmd_i.sample_fetch || cmd_i.point_fetch;
  assign ram_raddr = cmd_i.point_fetch ? point_slot : oldest_q;

  sfph_ram #(
    .WIDTH (EntryW),
    .DEPTH (POINT_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_side_o  = out_side_q;
  assign out_mid_o   = out_mid_q;
  assign out_age_o   = out_age_q;
  assign out_hit_o   = out_hit_q;
  assign out_held_o  = out_held_q;

endmodule

FILE: rtl/sfph_chk.sv
module sfph_chk #(
  parameter int POINT_SLOTS = 512,
  parameter int SAMPLE_BITS = 16,
  localparam int CntW = $clog2(POINT_SLOTS + 1)
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [SAMPLE_BITS-1:0]       side_i,
  input logic [SAMPLE_BITS-1:0]       mid_i,
  input logic [sfph_pkg::AGE_W-1:0]   age_i,
  input logic                         hit_i,
  input logic [CntW-1:0]              held_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(side_i) && $stable(mid_i) &&
      $stable(age_i) && $stable(hit_i) && $stable(held_i))
  else $error("result changed while stalled");

  // Count never exceeds the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> held_i <= CntW'(POINT_SLOTS))
  else $error("point count above ring size");

  // A miss carries zero point data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> side_i == '0 && mid_i == '0 && age_i == '0)
  else $error("missed read carries point data");

  // A hit needs at least one retained point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> held_i != '0)
  else $error("hit reported on empty history");

endmodule

bind stereo_field_point_history sfph_chk #(
  .POINT_SLOTS (POINT_SLOTS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sfph_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .side_i      (out_ch.side_value),
  .mid_i       (out_ch.mid_value),
  .age_i       (out_ch.normalized_age),
  .hit_i       (out_ch.point_valid),
  .held_i      (out_ch.points_held)
);

FILE: verif/stereo_field_point_history_test.sv
module stereo_field_point_history_test;
  import sfph_pkg::*;

  localparam int SLOTS = 512;
  // Request code the block has no use for; it must be swallowed silently.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // A sample frame gives no result but occupies the block through its steps, so
  // allow a margin for it to finish before touching the registers.
  localparam int DRAIN_CYCLES = 8;
  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic signed [15:0] side;
    logic signed [15:0] mid;
    logic [15:0]        age;
    logic               valid;
    logic [9:0]         held;
  } point_read_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sfph_in_if  #(.SAMPLE_BITS(16), .POINT_SLOTS(SLOTS)) in_ch ();
  sfph_out_if #(.SAMPLE_BITS(16), .POINT_SLOTS(SLOTS)) out_ch ();

  stereo_field_point_history dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Own copy of the point history, mirrored on every accepted request.
  logic signed [15:0] hist_side  [SLOTS];
  logic signed [15:0] hist_mid   [SLOTS];
  logic [31:0]        hist_stamp [SLOTS];
  logic [8:0]         first_slot;
  logic [9:0]         point_count;
  logic [31:0]        frame_no;
  logic [15:0]        skip_left;

  // Own copy of the registers.
  logic [15:0] reg_stride;
  logic [30:0] reg_window;
  logic [31:0] reg_recip;
  logic        reg_mono;

  point_read_t pending_points[$];

  int  errors;
  int  quiet;
  int  requests_sent;
  int  reads_checked;
  int  clears_sent;
  int  writes_done;
  int  peak_held;
  bit  steady;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Advance the mirrored history by one accepted request; queue the point
  // that a read must return.
  function automatic void track_request(input logic [REQ_W-1:0] req,
                                        input logic signed [15:0] left,
                                        input logic signed [15:0] right,
                                        input logic [8:0] idx);
    logic signed [16:0] diff;
    logic signed [16:0] total;
    logic [8:0]         dest;
    logic [8:0]         slot;
    logic [31:0]        win;
    logic [15:0]        stride;
    logic [31:0]        age;
    logic [63:0]        prod;
    point_read_t        rd;
    if (req == REQ_SAMPLE) begin
      stride = (reg_stride == 16'd0) ? 16'd1 : reg_stride;
      win    = (reg_window == 31'd0) ? 32'd1 : {1'b0, reg_window};
      if (skip_left == 16'd0) begin
        // Overwrite the oldest slot once the ring is full.
        if (point_count >= SLOTS) begin
          dest       = first_slot;
          first_slot = first_slot + 9'd1;
        end else begin
          dest        = first_slot + point_count[8:0];
          point_count = point_count + 10'd1;
        end
        if (reg_mono) begin
          hist_side[dest] = '0;
          hist_mid[dest]  = left;
        end else begin
          // Halve with a floor: drop the low bit of the 17-bit value.
          diff  = right - left;
          total = left + right;
          hist_side[dest] = diff[16:1];
          hist_mid[dest]  = total[16:1];
        end
        hist_stamp[dest] = frame_no;
        skip_left = stride - 16'd1;
      end else begin
        skip_left = skip_left - 16'd1;
      end
      frame_no = frame_no + 32'd1;
      // Expire at most one point per frame.
      if (point_count != 0 && (frame_no - 32'd1 - hist_stamp[first_slot]) >= win) begin
        first_slot  = first_slot + 9'd1;
        point_count = point_count - 10'd1;
      end
      if (int'(point_count) > peak_held) peak_held = int'(point_count);
    end else if (req == REQ_READ) begin
      rd = '0;
      rd.held = point_count;
      if ({1'b0, idx} < point_count) begin
        slot = first_slot + idx;
        age  = frame_no - 32'd1 - hist_stamp[slot];
        prod = ({32'd0, age} * {32'd0, reg_recip}) >> 16;
        rd.side  = hist_side[slot];
        rd.mid   = hist_mid[slot];
        rd.age   = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
        rd.valid = 1'b1;
      end
      pending_points.push_back(rd);
    end else if (req == REQ_CLEAR) begin
      first_slot  = '0;
      point_count = '0;
      frame_no    = '0;
      skip_left   = '0;
      clears_sent++;
    end
  endfunction

  function automatic logic [31:0] recip_for(input logic [31:0] window);
    logic [63:0] q;
    if (window <= 32'd1) return 32'hFFFF_FFFF;
    q = 64'h1_0000_0000 / window;
    return q[31:0];
  endfunction

  // Mostly random codes, with the range limits and the values around zero
  // turning up often enough to matter.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one request and hold it until the block takes the transfer. Call
  // at a rising edge; returns at the edge of the transfer with valid still up.
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic signed [15:0] left,
                              input logic signed [15:0] right,
                              input logic [8:0] idx);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= req;
    in_ch.left_sample  <= left;
    in_ch.right_sample <= right;
    in_ch.read_index   <= idx;
    do @(posedge clk_i); while (!in_ch.ready);
    track_request(req, left, right, idx);
    requests_sent++;
  endtask

  // Drop valid, wait for every queued point to come back, then let a frame in
  // flight finish before anything else happens.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_POINT_STRIDE:   reg_stride = data[15:0];
      CFG_WINDOW_FRAMES:  reg_window = data[30:0];
      CFG_AGE_RECIPROCAL: reg_recip  = data;
      CFG_MONO_MODE:      reg_mono   = data[0];
      default: ;
    endcase
    writes_done++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [31:0] stride, input logic [31:0] window,
                                input logic [31:0] recip, input logic [31:0] mono);
    settle();
    write_reg(CFG_POINT_STRIDE, stride);
    write_reg(CFG_WINDOW_FRAMES, window);
    write_reg(CFG_AGE_RECIPROCAL, recip);
    write_reg(CFG_MONO_MODE, mono);
  endtask

  // Random mix of requests; reads aim mostly at held points, sometimes just
  // past the end and sometimes anywhere in the index range.
  task automatic run_mix(input int items, input int sample_pct, input int read_pct,
                         input int clear_pct);
    int         roll;
    logic [8:0] idx;
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) idx = 9'($urandom_range(0, point_count));
      else idx = 9'($urandom);
      if (roll < sample_pct)
        send_request(REQ_SAMPLE, pick_sample(), pick_sample(), idx);
      else if (roll < sample_pct + read_pct)
        send_request(REQ_READ, pick_sample(), pick_sample(), idx);
      else if (roll < sample_pct + read_pct + clear_pct)
        send_request(REQ_CLEAR, pick_sample(), pick_sample(), idx);
      else
        send_request(REQ_UNUSED, pick_sample(), pick_sample(), idx);
    end
  endtask

  // Reads on an empty history: nothing held at either end of the index range.
  task automatic test_empty_reads();
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd0);
    send_request(REQ_READ, 16'sh7FFF, 16'sh8000, 9'd511);
  endtask

  // Corner pairs for the halving, under the reset register values, and reads of
  // them; then the unused code, a clear and a read.
  task automatic test_sample_extremes();
    send_request(REQ_SAMPLE, 16'sh8000, 16'sh8000, 9'd0);
    send_request(REQ_SAMPLE, 16'sh7FFF, 16'sh7FFF, 9'd0);
    send_request(REQ_SAMPLE, 16'sh8000, 16'sh7FFF, 9'd0);
    send_request(REQ_SAMPLE, 16'sh7FFF, 16'sh8000, 9'd0);
    send_request(REQ_SAMPLE, 16'shFFFF, 16'sh0000, 9'd0);
    send_request(REQ_SAMPLE, 16'sh0000, 16'shFFFF, 9'd0);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd0);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd3);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd5);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd6);
    send_request(REQ_UNUSED, 16'sh1234, 16'sh4321, 9'd0);
    send_request(REQ_CLEAR, 16'sh0000, 16'sh0000, 9'd0);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd0);
  endtask

  // Single channel: side held at zero, mid is the left sample, right ignored.
  task automatic test_mono_mode();
    apply_settings(32'd1, 32'd48000, 32'd89478, 32'd1);
    send_request(REQ_SAMPLE, 16'sh8000, 16'sh0005, 9'd0);
    send_request(REQ_SAMPLE, 16'sh7FFF, 16'shFFFF, 9'd0);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd0);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd1);
  endtask

  // Zero stride and zero window act as one; then the widest stride and window
  // with a full-scale reciprocal, so the age saturates.
  task automatic test_stride_window_edges();
    apply_settings(32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_CLEAR, 16'sh0000, 16'sh0000, 9'd0);
    send_request(REQ_SAMPLE, 16'sh0100, 16'shFF00, 9'd0);
    send_request(REQ_SAMPLE, 16'sh0003, 16'sh0004, 9'd0);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd0);
    apply_settings(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_CLEAR, 16'sh0000, 16'sh0000, 9'd0);
    send_request(REQ_SAMPLE, 16'sh4000, 16'shC000, 9'd0);
    send_request(REQ_SAMPLE, 16'sh0001, 16'sh0001, 9'd0);
    send_request(REQ_READ, 16'sh0000, 16'sh0000, 9'd0);
  endtask

  // Fill past the slot count under a huge window so the ring overwrites its
  // oldest entries; the first stretch runs with both sides never idling.
  task automatic test_ring_overwrite();
    apply_settings(32'd1, 32'h7FFF_FFFF, recip_for(32'h7FFF_FFFF), 32'd0);
    send_request(REQ_CLEAR, 16'sh0000, 16'sh0000, 9'd0);
    steady = 1'b1;
    run_mix(250, 86, 13, 0);
    steady = 1'b0;
    run_mix(400, 86, 13, 0);
  endtask

  // Lower the window on a full ring: the backlog drains one point per frame
  // while the stale ages saturate.
  task automatic test_window_drain();
    apply_settings(32'd4, 32'd24, recip_for(32'd24), 32'd0);
    run_mix(220, 80, 20, 0);
  endtask

  // Random register settings, each followed by a random mix of requests.
  task automatic test_random_settings();
    logic [31:0] stride;
    logic [31:0] window;
    logic [31:0] recip;
    for (int phase = 0; phase < 6; phase++) begin
      stride = $urandom_range(0, 5);
      case ($urandom_range(0, 3))
        0:       window = 32'd0;
        1:       window = 32'd1;
        2:       window = $urandom_range(2, 64);
        default: window = $urandom_range(65, 3000);
      endcase
      case ($urandom_range(0, 5))
        0:       recip = 32'd0;
        1:       recip = $urandom;
        2:       recip = 32'hFFFF_FFFF;
        default: recip = recip_for(window);
      endcase
      apply_settings(stride, window, recip, $urandom_range(0, 1));
      steady = (phase == 0);
      run_mix(125, 50, 42, 2);
    end
    steady = 1'b0;
  endtask

  // Hold ready low at random, about 31 percent of the time, except in steady stretches.
  always @(posedge clk_i) begin
    out_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  // Compare every result transfer with the oldest queued point.
  always @(posedge clk_i) begin
    point_read_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("result transfer with no read outstanding");
        errors++;
      end else begin
        want = pending_points.pop_front();
        reads_checked++;
        if (out_ch.side_value !== want.side) begin
          $error("side_value: expected %0d, got %0d", want.side, out_ch.side_value);
          errors++;
        end
        if (out_ch.mid_value !== want.mid) begin
          $error("mid_value: expected %0d, got %0d", want.mid, out_ch.mid_value);
          errors++;
        end
        if (out_ch.normalized_age !== want.age) begin
          $error("normalized_age: expected %0d, got %0d", want.age, out_ch.normalized_age);
          errors++;
        end
        if (out_ch.point_valid !== want.valid) begin
          $error("point_valid: expected %0d, got %0d", want.valid, out_ch.point_valid);
          errors++;
        end
        if (out_ch.points_held !== want.held) begin
          $error("points_held: expected %0d, got %0d", want.held, out_ch.points_held);
          errors++;
        end
      end
    end
  end

  // End the run if no transfer happens on either channel for too long.
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("stereo_field_point_history_test: errors");
    $finish;
  end

  initial begin
    errors        = 0;
    requests_sent = 0;
    reads_checked = 0;
    clears_sent   = 0;
    writes_done   = 0;
    peak_held     = 0;
    steady        = 1'b0;
    first_slot    = '0;
    point_count   = '0;
    frame_no      = '0;
    skip_left     = '0;
    reg_stride    = STRIDE_RST;
    reg_window    = WINDOW_RST;
    reg_recip     = RECIP_RST;
    reg_mono      = 1'b0;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_POINT_STRIDE;
    cfg_data_i         <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_SAMPLE;
    in_ch.left_sample  <= '0;
    in_ch.right_sample <= '0;
    in_ch.read_index   <= '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_sample_extremes();
    test_mono_mode();
    test_stride_window_edges();
    test_ring_overwrite();
    test_window_drain();
    test_random_settings();

    settle();
    if (pending_points.size() != 0) begin
      $error("%0d point reads never answered", pending_points.size());
      errors++;
    end

    $display("covered %0d requests (%0d point reads checked, %0d clears), %0d register writes",
             requests_sent, reads_checked, clears_sent, writes_done);
    $display("history peaked at %0d points, ring overwrite and window drain included",
             peak_held);
    if (errors == 0) begin
      $display("stereo_field_point_history_test: clean");
    end else begin
      $display("stereo_field_point_history_test: errors");
    end
    $finish;
  end

endmodule
